// ===== sv/htec_pkg.sv =====
// Package for the helium tube efficiency correction block.
// Widths, register indexes and pipeline word types; no dependencies.
package htec_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned WlWidth     = 24;
  localparam int unsigned ValWidth    = 32;
  localparam int unsigned ErrWidth    = 32;
  localparam int unsigned EffWidth    = 24;
  localparam int unsigned CfgWidth    = 24;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned SeriesTerms = 12;
  localparam int unsigned Halvings    = 6;
  localparam int unsigned DivSteps    = EffWidth;

  localparam logic [CfgWidth-1:0] ScaleReset = 24'h01_0000;
  localparam logic [EffWidth-1:0] EffMax     = '1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgExpConst   = 2'd0,
    CfgScaleFactor = 2'd1,
    CfgErrorMode  = 2'd2
  } cfg_idx_e;

  // word fields that ride along every stage
  typedef struct packed {
    logic                       byp;
    logic signed [ValWidth-1:0] val;
    logic [ErrWidth-1:0]        err;
  } side_t;

  // series state: multiplier, last term, odd and even partial sums
  typedef struct packed {
    logic [30:0] m;
    logic [30:0] t;
    logic [34:0] so;
    logic [34:0] se;
    logic        below_half;
    logic        cap;
  } ser_t;

  typedef struct packed {
    logic        below_half;
    logic        cap;
    logic [34:0] dsm;
  } dn_t;

  typedef struct packed {
    logic [32:0]         den;
    logic [32:0]         rem;
    logic [EffWidth-1:0] quo;
    logic                sat;
  } div_t;

  typedef struct packed {
    logic signed [ValWidth-1:0] val;
    logic [ErrWidth-1:0]        err;
    logic [EffWidth-1:0]        eff;
    logic                       ovf;
  } res_t;

endpackage

// ===== sv/htec_if.sv =====
// Stream interfaces for input and result words of the efficiency correction.
// Depends on htec_pkg for field widths.
interface htec_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [htec_pkg::WlWidth-1:0]         wavelength;
  logic signed [htec_pkg::ValWidth-1:0] measured_value;
  logic [htec_pkg::ErrWidth-1:0]        measured_error;
  logic                                 bypass;

  modport source (output valid, wavelength, measured_value, measured_error, bypass,
                  input ready);
  modport sink   (input valid, wavelength, measured_value, measured_error, bypass,
                  output ready);
endinterface

interface htec_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [htec_pkg::ValWidth-1:0] corrected_value;
  logic [htec_pkg::ErrWidth-1:0]        corrected_error;
  logic [htec_pkg::EffWidth-1:0]        efficiency;
  logic                                 overflow;

  modport source (output valid, corrected_value, corrected_error, efficiency, overflow,
                  input ready);
  modport sink   (input valid, corrected_value, corrected_error, efficiency, overflow,
                  output ready);
endinterface

// ===== sv/helium_tube_efficiency_correct.sv =====
// Throughput: one word per cycle while the skid register is empty.
// The 71 pipeline stages are the alpha product, series setup, a 12-term series (three
// stages for each term after the first), series end, six squarings, the denominator, divider
// setup, a 24-step restoring divider and three product stages; the output register holds
// the result, and a skid register keeps the pipeline running one word past a stalled sink.
// Reset: asynchronous, active low; clears valids and sets registers to their reset values.
// Depends on htec_pkg and htec_if.
module helium_tube_efficiency_correct (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [htec_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [htec_pkg::CfgWidth-1:0]       cfg_data_i,
  htec_in_if.sink                             in_word,
  htec_out_if.source                          out_word
);

  localparam int unsigned NTerms = htec_pkg::SeriesTerms - 1;
  localparam int unsigned SerEnd = 2 + 3 * NTerms;
  localparam int unsigned NSt    = SerEnd + 1 + htec_pkg::Halvings + 2
                                   + htec_pkg::DivSteps + 3;

  // configuration
  logic [htec_pkg::CfgWidth-1:0] exp_q, scale_q;
  logic                          mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      scale_q <= htec_pkg::ScaleReset;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (htec_pkg::cfg_idx_e'(cfg_idx_i))
        htec_pkg::CfgExpConst:    exp_q   <= cfg_data_i;
        htec_pkg::CfgScaleFactor: scale_q <= cfg_data_i;
        htec_pkg::CfgErrorMode:   mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic           skid_v_q, out_v_q;
  logic [NSt-1:0] v_q;
  htec_pkg::side_t side_q [NSt-1];

  assign en            = !skid_v_q;
  assign in_word.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSt-2:0], in_word.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{byp: in_word.bypass, val: in_word.measured_value,
                     err: in_word.measured_error};
      for (int i = 1; i < NSt - 1; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // alpha product and series setup
  logic [47:0]    p_q;
  logic [36:0]    alpha;
  logic           a_small, a_cap;
  logic [30:0]    a_m;
  htec_pkg::ser_t ser_chain [NTerms+1];
  htec_pkg::ser_t ser_init_q;

  assign alpha   = p_q[36:0];
  assign a_cap   = |p_q[47:37];
  assign a_small = (alpha[36:31] == '0);
  assign a_m     = a_small ? alpha[30:0] : alpha[36:htec_pkg::Halvings];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q        <= 48'(exp_q) * 48'(in_word.wavelength);
      ser_init_q <= '{m: a_m, t: a_m, so: 35'(a_m), se: '0, below_half: a_small,
                      cap: a_cap};
    end
  end

  assign ser_chain[0] = ser_init_q;

  for (genvar j = 0; j < NTerms; j++) begin : g_term
    localparam int unsigned K = j + 2;
    localparam logic [29:0] Recip = 30'((2 ** 30) / K);

    htec_pkg::ser_t a_ser_q, b_ser_q, c_ser_q, c_ser_d;
    logic [29:0]    a_x_q, b_x_q, b_q0_q;
    logic [61:0]    prod;
    logic [59:0]    rprod;
    logic [33:0]    rem;
    logic [29:0]    quo;

    assign prod  = 62'(ser_chain[j].t) * 62'(ser_chain[j].m);
    assign rprod = 60'(a_x_q) * 60'(Recip);
    assign rem   = 34'(b_x_q) - 34'(b_q0_q) * 34'(K);
    assign quo   = (rem >= 34'(K)) ? b_q0_q + 30'd1 : b_q0_q;

    always_comb begin
      c_ser_d   = b_ser_q;
      c_ser_d.t = 31'(quo);
      if (K % 2 == 1) begin
        c_ser_d.so = b_ser_q.so + 35'(quo);
      end else begin
        c_ser_d.se = b_ser_q.se + 35'(quo);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_ser_q <= ser_chain[j];
        a_x_q   <= prod[61:32];
        b_ser_q <= a_ser_q;
        b_x_q   <= a_x_q;
        b_q0_q  <= rprod[59:30];
        c_ser_q <= c_ser_d;
      end
    end

    assign ser_chain[j+1] = c_ser_q;
  end

  // series end, squarings
  htec_pkg::ser_t ser_last;
  logic [34:0]    dsm;
  logic [35:0]    epos, ediff;
  logic [31:0]    e32;
  htec_pkg::dn_t  sq_dn_q [htec_pkg::Halvings+1];
  logic [31:0]    sq_e_q  [htec_pkg::Halvings+1];

  assign ser_last = ser_chain[NTerms];
  assign dsm      = (ser_last.so >= ser_last.se) ? ser_last.so - ser_last.se : '0;
  assign epos     = 36'h1_0000_0000 + 36'(ser_last.se);
  assign ediff    = (epos >= 36'(ser_last.so)) ? epos - 36'(ser_last.so) : '0;
  assign e32      = (ediff > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : ediff[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_dn_q[0] <= '{below_half: ser_last.below_half, cap: ser_last.cap, dsm: dsm};
      sq_e_q[0]  <= e32;
    end
  end

  for (genvar i = 0; i < htec_pkg::Halvings; i++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(sq_e_q[i]) * 64'(sq_e_q[i]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_dn_q[i+1] <= sq_dn_q[i];
        sq_e_q[i+1]  <= sq[63:32];
      end
    end
  end

  // denominator and divider
  htec_pkg::dn_t dn_last;
  logic [32:0]   den_q;
  htec_pkg::div_t div_q [htec_pkg::DivSteps+1];

  assign dn_last = sq_dn_q[htec_pkg::Halvings];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dn_last.cap) begin
        den_q <= 33'h1_0000_0000;
      end else if (dn_last.below_half) begin
        den_q <= dn_last.dsm[32:0];
      end else begin
        den_q <= 33'h1_0000_0000 - 33'(sq_e_q[htec_pkg::Halvings]);
      end
      div_q[0] <= '{den: den_q, rem: {1'b0, scale_q, 8'b0}, quo: '0,
                    sat: (den_q == '0) || ({1'b0, scale_q, 8'b0} >= den_q)};
    end
  end

  for (genvar i = 0; i < htec_pkg::DivSteps; i++) begin : g_div
    logic [33:0] r2;
    logic        ge;
    assign r2 = {div_q[i].rem, 1'b0};
    assign ge = (r2 >= {1'b0, div_q[i].den});
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i+1].den <= div_q[i].den;
        div_q[i+1].sat <= div_q[i].sat;
        div_q[i+1].quo <= {div_q[i].quo[htec_pkg::DivSteps-2:0], ge};
        div_q[i+1].rem <= ge ? 33'(r2 - {1'b0, div_q[i].den}) : r2[32:0];
      end
    end
  end

  // value and error products
  localparam int unsigned SM1 = NSt - 3;
  localparam int unsigned SM2 = NSt - 2;

  htec_pkg::div_t div_last;
  logic [htec_pkg::EffWidth-1:0] eff;
  logic [31:0]  mag;
  logic [55:0]  vprod, eprod;
  logic [39:0]  mv_q, et_q;
  logic [htec_pkg::EffWidth-1:0] eff1_q, eff2_q;
  logic         neg1_q, ovf1_q;

  assign div_last = div_q[htec_pkg::DivSteps];
  assign eff      = div_last.sat ? htec_pkg::EffMax : div_last.quo;
  assign mag      = side_q[SM1-1].val[31] ? 32'(-side_q[SM1-1].val) : 32'(side_q[SM1-1].val);
  assign vprod    = 56'(mag) * 56'(eff);
  assign eprod    = 56'(side_q[SM1-1].err) * 56'(eff);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mv_q   <= vprod[55:htec_pkg::FracBits];
      et_q   <= eprod[55:htec_pkg::FracBits];
      eff1_q <= eff;
      neg1_q <= side_q[SM1-1].val[31];
      ovf1_q <= div_last.sat;
    end
  end

  logic [31:0] val2;
  logic        vsat;
  logic [43:0] lo_p, hi_p;
  logic [43:0] lo_q, hi_q;
  logic [31:0] val2_q, e0_q;
  logic        ovf2_q, e0sat_q;

  always_comb begin
    if (neg1_q) begin
      vsat = (mv_q > 40'h00_8000_0000);
      val2 = vsat ? 32'h8000_0000 : 32'(-mv_q[31:0]);
    end else begin
      vsat = (mv_q > 40'h00_7FFF_FFFF);
      val2 = vsat ? 32'h7FFF_FFFF : mv_q[31:0];
    end
  end

  assign lo_p = 44'(et_q[19:0]) * 44'(eff1_q);
  assign hi_p = 44'(et_q[39:20]) * 44'(eff1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q    <= lo_p;
      hi_q    <= hi_p;
      val2_q  <= val2;
      e0_q    <= et_q[31:0];
      e0sat_q <= |et_q[39:32];
      ovf2_q  <= ovf1_q | vsat;
      eff2_q  <= eff1_q;
    end
  end

  logic [63:0] e1prod;
  logic [47:0] e1;
  logic        e1sat;
  htec_pkg::res_t res, res_q;

  assign e1prod = {hi_q, 20'b0} + 64'(lo_q);
  assign e1     = e1prod[63:htec_pkg::FracBits];
  assign e1sat  = |e1[47:32];

  always_comb begin
    if (side_q[SM2].byp) begin
      res = '{val: side_q[SM2].val, err: side_q[SM2].err, eff: '0, ovf: 1'b0};
    end else if (mode_q) begin
      res = '{val: val2_q, err: e1sat ? 32'hFFFF_FFFF : e1[31:0], eff: eff2_q,
              ovf: ovf2_q | e1sat};
    end else begin
      res = '{val: val2_q, err: e0sat_q ? 32'hFFFF_FFFF : e0_q, eff: eff2_q,
              ovf: ovf2_q | e0sat_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res;
    end
  end

  // output register with skid
  htec_pkg::res_t out_d_q, skid_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_word.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (v_q[NSt-1]) begin
      if (out_v_q && !out_word.ready) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_word.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_word.ready) begin
        out_d_q <= skid_d_q;
      end
    end else if (v_q[NSt-1]) begin
      if (out_v_q && !out_word.ready) begin
        skid_d_q <= res_q;
      end else begin
        out_d_q <= res_q;
      end
    end
  end

  assign out_word.valid           = out_v_q;
  assign out_word.corrected_value = out_d_q.val;
  assign out_word.corrected_error = out_d_q.err;
  assign out_word.efficiency      = out_d_q.eff;
  assign out_word.overflow        = out_d_q.ovf;

endmodule

// ===== test/tb_helium_tube_efficiency_correct.sv =====
// Testbench for helium_tube_efficiency_correct: random and directed words with bursty input
// and a stalling sink; results checked against an in-bench predictor or typed directed rows.
// Depends on htec_pkg, htec_if and the block itself.
`timescale 1ns / 100ps

module tb_helium_tube_efficiency_correct;

  localparam logic [htec_pkg::CfgIdxWidth-1:0] CfgUnused = 2'd3;
  localparam int unsigned PipeDrain = 90;
  localparam int unsigned PhaseWords = 190;
  localparam int unsigned NumPhases = 8;

  typedef struct {
    logic [htec_pkg::WlWidth-1:0]  wl;
    logic [htec_pkg::ValWidth-1:0] val;
    logic [htec_pkg::ErrWidth-1:0] err;
    logic                          byp;
    bit                            typed;
    htec_pkg::res_t                want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [htec_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [htec_pkg::CfgWidth-1:0] cfg_data_i = '0;

  htec_in_if  in_w();
  htec_out_if out_w();

  helium_tube_efficiency_correct dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_word(in_w), .out_word(out_w)
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [htec_pkg::CfgWidth-1:0] exp_k;
  logic [htec_pkg::CfgWidth-1:0] scale_k;
  logic                          err_sq;

  htec_pkg::res_t eff_q[$];
  int   mism;
  int   results_seen;
  int   burst_left;

  dir_row_t dir_tab[] = '{
    '{24'hFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1, '{32'h80000000, 32'hFFFFFFFF, 24'h0, 1'b0}},
    '{24'h000000, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1, '{32'h7FFFFFFF, 32'h0, 24'h0, 1'b0}},
    '{24'h000000, 32'h00000000, 32'h00000000, 1'b0, 1, '{32'h0, 32'h0, 24'hFFFFFF, 1'b1}},
    '{24'h000000, 32'h7FFFFFFF, 32'h00000000, 1'b0, 1, '{32'h7FFFFFFF, 32'h0, 24'hFFFFFF, 1'b1}},
    '{24'h000000, 32'h80000000, 32'h00000000, 1'b0, 1, '{32'h80000000, 32'h0, 24'hFFFFFF, 1'b1}},
    '{24'h000000, 32'h00000000, 32'hFFFFFFFF, 1'b0, 1,
      '{32'h0, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1}},
    '{24'hFFFFFF, 32'h00010000, 32'h00010000, 1'b0, 0, '{default: '0}},
    '{24'h000001, 32'h00010000, 32'h00010000, 1'b0, 0, '{default: '0}},
    '{24'h007FFF, 32'hFFFFFFFF, 32'h00000001, 1'b0, 0, '{default: '0}},
    '{24'h008000, 32'h00000001, 32'h00000100, 1'b0, 0, '{default: '0}},
    '{24'h010000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 0, '{default: '0}},
    '{24'h1FFFFF, 32'h80000000, 32'h00020000, 1'b0, 0, '{default: '0}},
    '{24'h200000, 32'h12345678, 32'h00ABCDEF, 1'b0, 0, '{default: '0}},
    '{24'h080000, 32'hFFFF0000, 32'h0000FFFF, 1'b0, 0, '{default: '0}},
    '{24'h000100, 32'h00001000, 32'h00001000, 1'b0, 0, '{default: '0}},
    '{24'h0C0000, 32'h00300000, 32'h00300000, 1'b0, 0, '{default: '0}}
  };

  // 12-term series; with_one gives exp(-x), else 1 - exp(-x), x in Q.32
  function automatic longint unsigned series_q32(longint unsigned x, bit with_one);
    longint unsigned t, pos, neg;
    t   = with_one ? 64'h1_0000_0000 : x;
    pos = with_one ? 64'h1_0000_0000 : 64'd0;
    neg = 0;
    for (int k = 1; k <= htec_pkg::SeriesTerms; k++) begin
      if (with_one || k > 1) t = ((t * x) >> 32) / k;
      if ((k & 1) == (with_one ? 1 : 0)) neg += t;
      else pos += t;
    end
    return (pos >= neg) ? pos - neg : 64'd0;
  endfunction

  function automatic htec_pkg::res_t correct_word(logic [htec_pkg::WlWidth-1:0] wl,
                                                  logic [htec_pkg::ValWidth-1:0] v,
                                                  logic [htec_pkg::ErrWidth-1:0] e, logic b);
    htec_pkg::res_t r;
    longint unsigned p, den, ex, eff, mag, q, t, cerr;
    bit ovf;
    ovf = 0;
    if (b) begin
      r.val = v; r.err = e; r.eff = '0; r.ovf = 1'b0;
      return r;
    end
    p = longint'(exp_k) * longint'(wl);
    if ((p >> 37) != 0) den = 64'h1_0000_0000;
    else if (p < 64'h8000_0000) den = series_q32(p, 0);
    else begin
      ex = series_q32(p >> htec_pkg::Halvings, 1);
      for (int i = 0; i < htec_pkg::Halvings; i++) begin
        if (ex > 64'hFFFF_FFFF) ex = 64'hFFFF_FFFF;
        ex = (ex * ex) >> 32;
      end
      if (ex > 64'hFFFF_FFFF) ex = 64'hFFFF_FFFF;
      den = 64'h1_0000_0000 - ex;
    end
    if (den == 0) begin
      eff = 64'hFF_FFFF; ovf = 1;
    end else begin
      eff = (longint'(scale_k) << 32) / den;
      if (eff > 64'hFF_FFFF) begin
        eff = 64'hFF_FFFF; ovf = 1;
      end
    end
    mag = v[31] ? 64'h1_0000_0000 - longint'(v) : longint'(v);
    q = (mag * eff) >> htec_pkg::FracBits;
    if (v[31]) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000; ovf = 1;
      end
      r.val = 32'(64'h1_0000_0000 - q);
    end else begin
      if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF; ovf = 1;
      end
      r.val = 32'(q);
    end
    t = (longint'(e) * eff) >> htec_pkg::FracBits;
    if (!err_sq) cerr = t;
    else if (eff != 0 && t > 64'hFFFF_FFFF_FFFF_FFFF / eff) cerr = 64'h1_0000_0000;
    else cerr = (t * eff) >> htec_pkg::FracBits;
    if (cerr > 64'hFFFF_FFFF) begin
      cerr = 64'hFFFF_FFFF; ovf = 1;
    end
    r.err = 32'(cerr);
    r.eff = 24'(eff);
    r.ovf = ovf;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic push_word(logic [htec_pkg::WlWidth-1:0] wl, logic [htec_pkg::ValWidth-1:0] v,
                           logic [htec_pkg::ErrWidth-1:0] e, logic b, bit typed,
                           htec_pkg::res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_w.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_w.wavelength = wl;
    in_w.measured_value = v;
    in_w.measured_error = e;
    in_w.bypass = b;
    in_w.valid = 1'b1;
    do @(posedge clk_i); while (!in_w.ready);
    eff_q.push_back(typed ? want : correct_word(wl, v, e, b));
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [htec_pkg::CfgIdxWidth-1:0] idx,
                           logic [htec_pkg::CfgWidth-1:0] d);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      htec_pkg::CfgExpConst:    exp_k = d;
      htec_pkg::CfgScaleFactor: scale_k = d;
      htec_pkg::CfgErrorMode:   err_sq = d[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_w.valid = 1'b0;
    while (eff_q.size() != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic random_words(int n);
    logic [htec_pkg::WlWidth-1:0] wl;
    logic [htec_pkg::ValWidth-1:0] v;
    logic [htec_pkg::ErrWidth-1:0] e;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: wl = 24'($urandom);
        1: wl = 24'($urandom_range(0, 255)) << $urandom_range(0, 16);
        2: wl = 24'($urandom_range(0, 65535));
        default: wl = 24'($urandom_range(0, 16777215) >> $urandom_range(0, 23));
      endcase
      v = ($urandom_range(0, 2) == 0) ? 32'($signed($urandom_range(0, 2000000)) - 1000000)
                                      : $urandom;
      e = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 1 << 20)) : $urandom;
      push_word(wl, v, e, ($urandom_range(0, 7) == 0), 1'b0, '{default: '0});
    end
  endtask

  // sink: rotating stall patterns plus one long hold-off
  initial begin
    bit held;
    int cyc;
    held = 0;
    cyc = 0;
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!held && results_seen >= 250) begin
        held = 1;
        out_w.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        case ((cyc >> 8) & 3)
          0: out_w.ready = 1'b1;
          1: out_w.ready = 1'($urandom_range(0, 1));
          2: out_w.ready = ((cyc & 3) != 0);
          default: out_w.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    htec_pkg::res_t want;
    if (rst_ni && out_w.valid && out_w.ready) begin
      results_seen++;
      if (eff_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result word: val %h err %h eff %h ovf %b",
                                 out_w.corrected_value, out_w.corrected_error,
                                 out_w.efficiency, out_w.overflow);
      end else begin
        want = eff_q.pop_front();
        if (out_w.corrected_value !== want.val || out_w.corrected_error !== want.err ||
            out_w.efficiency !== want.eff || out_w.overflow !== want.ovf) begin
          mism++;
          if (mism <= 10)
            $display("mismatch: exp val %h err %h eff %h ovf %b, got %h %h %h %b",
                     want.val, want.err, want.eff, want.ovf, out_w.corrected_value,
                     out_w.corrected_error, out_w.efficiency, out_w.overflow);
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    mism = 0;
    results_seen = 0;
    burst_left = 0;
    exp_k = '0;
    scale_k = htec_pkg::ScaleReset;
    err_sq = 1'b0;
    in_w.valid = 1'b0;
    in_w.wavelength = '0;
    in_w.measured_value = '0;
    in_w.measured_error = '0;
    in_w.bypass = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    random_words(40);
    wait_drained();

    cfg_write(htec_pkg::CfgExpConst, 24'h010000);
    cfg_write(htec_pkg::CfgScaleFactor, 24'h010000);
    cfg_write(htec_pkg::CfgErrorMode, 24'd1);
    foreach (dir_tab[i])
      push_word(dir_tab[i].wl, dir_tab[i].val, dir_tab[i].err, dir_tab[i].byp,
                dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          cfg_write(htec_pkg::CfgExpConst, 24'h010000);
          cfg_write(htec_pkg::CfgScaleFactor, 24'h010000);
          cfg_write(htec_pkg::CfgErrorMode, 24'd0);
        end
        1: begin
          cfg_write(htec_pkg::CfgExpConst, 24'hFFFFFF);
          cfg_write(htec_pkg::CfgScaleFactor, 24'hFFFFFF);
          cfg_write(htec_pkg::CfgErrorMode, 24'd1);
        end
        2: begin
          cfg_write(htec_pkg::CfgExpConst, 24'd1);
          cfg_write(htec_pkg::CfgScaleFactor, 24'd1);
          cfg_write(htec_pkg::CfgErrorMode, 24'd0);
          cfg_write(CfgUnused, 24'hFFFFFF);
        end
        3: begin
          cfg_write(htec_pkg::CfgExpConst, 24'd0);
          cfg_write(htec_pkg::CfgScaleFactor, 24'd0);
          cfg_write(htec_pkg::CfgErrorMode, 24'd1);
        end
        default: begin
          cfg_write(htec_pkg::CfgExpConst, 24'($urandom) >> $urandom_range(0, 12));
          cfg_write(htec_pkg::CfgScaleFactor, 24'($urandom) >> $urandom_range(0, 12));
          cfg_write(htec_pkg::CfgErrorMode, 24'($urandom_range(0, 1)));
        end
      endcase
      random_words(PhaseWords);
      wait_drained();
    end

    if (mism == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/htec_pkg.sv
sv/htec_if.sv
sv/helium_tube_efficiency_correct.sv
test/tb_helium_tube_efficiency_correct.sv
